### hdl/dls_pkg.sv
// dls_pkg: shared widths, reset values, register indexes and the
// controller/datapath command and status structs of the dependency scheduler
// no dependencies
package dls_pkg;

  localparam int MaxStepsDef   = 26;
  localparam int MaxWorkersDef = 8;

  localparam int StepW    = 5;
  localparam int WorkW    = 9;
  localparam int TickW    = 16;
  localparam int WcW      = 4;
  localparam int BaseW    = 8;
  localparam int CfgIdxW  = 1;
  localparam int CfgDataW = 8;

  localparam logic [WcW-1:0]   WcReset   = 4'd5;
  localparam logic [BaseW-1:0] BaseReset = 8'd60;
  localparam logic [TickW-1:0] TickMax   = '1;

  // configuration register indexes
  localparam logic [CfgIdxW-1:0] CfgWorkerCount  = 1'b0;
  localparam logic [CfgIdxW-1:0] CfgBaseDuration = 1'b1;

  typedef struct packed {
    logic [StepW-1:0] before_step;
    logic [StepW-1:0] after_step;
    logic             last_edge;
  } edge_t;

  typedef struct packed {
    logic [TickW-1:0] total_ticks;
    logic             deadlock;
  } result_t;

  typedef struct packed {
    logic load_edge;
    logic init;
    logic queue;
    logic start;
    logic decr;
    logic retire;
    logic publish;
    logic dead;
  } dp_cmd_t;

  typedef struct packed {
    logic can_start;
    logic stuck;
    logic pend_any;
    logic all_done;
    logic out_busy;
  } dp_stat_t;

endpackage

### hdl/dependency_list_scheduler_top.sv
// dependency_list_scheduler_top: edge loader and list-schedule simulator
// depends on dls_pkg, dls_ctrl, dls_datapath
//
//  channel | direction | handshake           | payload
//  in      | input     | in_valid_i/stall_o  | dls_pkg::edge_t
//  out     | output    | out_valid_o/stall_i | dls_pkg::result_t
//  cfg     | input     | cfg_valid_i/ready_o | cfg_index_i, cfg_data_i
//
// an edge beat without last_edge is taken while the input is not stalled
// a last edge starts a run: countdowns load, then each tick queues ready
// steps, starts them while workers are free, counts down and retires;
// a deadlock ends the run; the result waits while the last one is stalled
// reset is asynchronous and leaves all stores empty; no clearing pass
// the finished result waits in its output register while new edges load
module dependency_list_scheduler_top #(
  parameter int MaxSteps   = dls_pkg::MaxStepsDef,
  parameter int MaxWorkers = dls_pkg::MaxWorkersDef
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         in_valid_i,
  output logic                         in_stall_o,
  input  dls_pkg::edge_t               in_data_i,
  output logic                         out_valid_o,
  input  logic                         out_stall_i,
  output dls_pkg::result_t             out_data_o,
  input  logic                         cfg_valid_i,
  output logic                         cfg_ready_o,
  input  logic [dls_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [dls_pkg::CfgDataW-1:0] cfg_data_i
);

  dls_pkg::dp_cmd_t  cmd;
  dls_pkg::dp_stat_t stat;

  assign cfg_ready_o = 1'b1;

  dls_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_last_i  (in_data_i.last_edge),
    .stat_i     (stat),
    .cmd_o      (cmd),
    .in_stall_o (in_stall_o)
  );

  dls_datapath #(
    .MaxSteps   (MaxSteps),
    .MaxWorkers (MaxWorkers)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cmd_i       (cmd),
    .stat_o      (stat),
    .in_data_i   (in_data_i),
    .cfg_we_i    (cfg_valid_i & cfg_ready_o),
    .cfg_index_i (cfg_index_i),
    .cfg_data_i  (cfg_data_i),
    .out_stall_i (out_stall_i),
    .out_valid_o (out_valid_o),
    .out_data_o  (out_data_o)
  );

endmodule

### hdl/dls_ctrl.sv
// dls_ctrl: sequencer for edge loading and the tick-by-tick schedule run
// depends on dls_pkg (command and status structs)
module dls_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  input  logic              in_last_i,
  input  dls_pkg::dp_stat_t stat_i,
  output dls_pkg::dp_cmd_t  cmd_o,
  output logic              in_stall_o
);

  typedef enum logic [7:0] {
    StLoad   = 8'b0000_0001,
    StInit   = 8'b0000_0010,
    StQueue  = 8'b0000_0100,
    StStart  = 8'b0000_1000,
    StCheck  = 8'b0001_0000,
    StDecr   = 8'b0010_0000,
    StRetire = 8'b0100_0000,
    StFin    = 8'b1000_0000
  } state_e;

  state_e state_q, state_d;
  logic   dead_q, dead_d;

  always_comb begin
    state_d = state_q;
    dead_d  = dead_q;
    cmd_o   = '0;
    case (state_q)
      StLoad: begin
        cmd_o.load_edge = in_valid_i;
        if (in_valid_i && in_last_i) begin
          state_d = StInit;
        end
      end
      StInit: begin
        cmd_o.init = 1'b1;
        state_d    = StQueue;
      end
      StQueue: begin
        cmd_o.queue = 1'b1;
        state_d     = StStart;
      end
      StStart: begin
        // one start per cycle while a worker is free, lowest queued index first
        if (stat_i.can_start) begin
          cmd_o.start = 1'b1;
        end else begin
          state_d = StCheck;
        end
      end
      StCheck: begin
        if (stat_i.stuck) begin
          dead_d  = 1'b1;
          state_d = StFin;
        end else begin
          state_d = StDecr;
        end
      end
      StDecr: begin
        cmd_o.decr = 1'b1;
        state_d    = StRetire;
      end
      StRetire: begin
        // hand back one worker per finished step
        if (stat_i.pend_any) begin
          cmd_o.retire = 1'b1;
        end else if (stat_i.all_done) begin
          state_d = StFin;
        end else begin
          state_d = StQueue;
        end
      end
      StFin: begin
        cmd_o.dead = dead_q;
        if (!stat_i.out_busy) begin
          cmd_o.publish = 1'b1;
          dead_d        = 1'b0;
          state_d       = StLoad;
        end
      end
      default: begin
        state_d = StLoad;
        dead_d  = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= StLoad;
      dead_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      dead_q  <= dead_d;
    end
  end

  assign in_stall_o = (state_q != StLoad);

endmodule

### hdl/dls_datapath.sv
// dls_datapath: step stores, per-step countdowns, worker pool, tick counter,
// configuration registers and the result register
// depends on dls_pkg
module dls_datapath #(
  parameter int MaxSteps   = dls_pkg::MaxStepsDef,
  parameter int MaxWorkers = dls_pkg::MaxWorkersDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  dls_pkg::dp_cmd_t              cmd_i,
  output dls_pkg::dp_stat_t             stat_o,
  input  dls_pkg::edge_t                in_data_i,
  input  logic                          cfg_we_i,
  input  logic [dls_pkg::CfgIdxW-1:0]   cfg_index_i,
  input  logic [dls_pkg::CfgDataW-1:0]  cfg_data_i,
  input  logic                          out_stall_i,
  output logic                          out_valid_o,
  output dls_pkg::result_t              out_data_o
);

  localparam int SIdxW = (MaxSteps > 1) ? $clog2(MaxSteps) : 1;
  localparam int FreeW = $clog2(MaxWorkers + 1);

  typedef logic [MaxSteps-1:0]       vec_t;
  typedef logic [dls_pkg::WorkW-1:0] work_t;

  // configuration
  logic [dls_pkg::WcW-1:0]   wc_q;
  logic [dls_pkg::BaseW-1:0] base_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wc_q   <= dls_pkg::WcReset;
      base_q <= dls_pkg::BaseReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        dls_pkg::CfgWorkerCount:  wc_q   <= cfg_data_i[dls_pkg::WcW-1:0];
        dls_pkg::CfgBaseDuration: base_q <= cfg_data_i[dls_pkg::BaseW-1:0];
        default: ;
      endcase
    end
  end

  // step stores, phase kept as one mask per phase (idle is none set)
  vec_t present_q, present_d;
  vec_t queued_q, queued_d;
  vec_t working_q, working_d;
  vec_t done_q, done_d;
  vec_t pend_q, pend_d;
  vec_t pred_q [MaxSteps];
  vec_t pred_d [MaxSteps];
  work_t wl_q [MaxSteps];
  logic [FreeW-1:0]          free_q, free_d;
  logic [dls_pkg::TickW-1:0] tick_q, tick_d;
  logic                      out_valid_q, out_valid_d;
  dls_pkg::result_t          out_q;

  vec_t  ready_vec, fin_vec, low_queued, low_pend, unfinished;
  work_t wl_init [MaxSteps];
  work_t wl_dec  [MaxSteps];
  logic  edge_ok;
  logic [SIdxW-1:0] bef_idx, aft_idx;
  logic [FreeW-1:0] wc_clamp;

  assign edge_ok = (32'(in_data_i.before_step) < MaxSteps) &&
                   (32'(in_data_i.after_step) < MaxSteps);
  assign bef_idx = SIdxW'(in_data_i.before_step);
  assign aft_idx = SIdxW'(in_data_i.after_step);

  always_comb begin
    if (wc_q == '0) begin
      wc_clamp = FreeW'(1);
    end else if (32'(wc_q) > MaxWorkers) begin
      wc_clamp = FreeW'(MaxWorkers);
    end else begin
      wc_clamp = FreeW'(wc_q);
    end
  end

  // per-step lanes
  always_comb begin
    for (int s = 0; s < MaxSteps; s++) begin
      ready_vec[s] = present_q[s] & ~(queued_q[s] | working_q[s] | done_q[s]) &
                     ((pred_q[s] & ~done_q) == '0);
      wl_init[s]   = work_t'(base_q) + work_t'(s) + work_t'(1);
      wl_dec[s]    = (wl_q[s] == '0) ? '0 : wl_q[s] - work_t'(1);
      fin_vec[s]   = working_q[s] & (wl_dec[s] == '0);
    end
  end

  // lowest set bit isolation
  assign low_queued = queued_q & (~queued_q + MaxSteps'(1));
  assign low_pend   = pend_q & (~pend_q + MaxSteps'(1));
  assign unfinished = present_q & ~done_q;

  always_comb begin
    present_d = present_q;
    queued_d  = queued_q;
    working_d = working_q;
    done_d    = done_q;
    pend_d    = pend_q;
    pred_d    = pred_q;
    free_d    = free_q;
    tick_d    = tick_q;
    if (cmd_i.load_edge && edge_ok) begin
      present_d[bef_idx]          = 1'b1;
      present_d[aft_idx]          = 1'b1;
      pred_d[aft_idx][bef_idx]    = 1'b1;
    end
    if (cmd_i.init) begin
      queued_d  = '0;
      working_d = '0;
      done_d    = '0;
      pend_d    = '0;
      free_d    = wc_clamp;
      tick_d    = '0;
    end
    if (cmd_i.queue) begin
      queued_d = queued_q | ready_vec;
    end
    if (cmd_i.start) begin
      queued_d  = queued_q & ~low_queued;
      working_d = working_q | low_queued;
      free_d    = free_q - FreeW'(1);
    end
    if (cmd_i.decr) begin
      working_d = working_q & ~fin_vec;
      done_d    = done_q | fin_vec;
      pend_d    = pend_q | fin_vec;
      if (tick_q != dls_pkg::TickMax) begin
        tick_d = tick_q + dls_pkg::TickW'(1);
      end
    end
    if (cmd_i.retire) begin
      pend_d = pend_q & ~low_pend;
      free_d = free_q + FreeW'(1);
    end
    if (cmd_i.publish) begin
      // stores cleared once the result is taken into the output register
      present_d = '0;
      queued_d  = '0;
      working_d = '0;
      done_d    = '0;
      pend_d    = '0;
      free_d    = '0;
      tick_d    = '0;
      for (int s = 0; s < MaxSteps; s++) begin
        pred_d[s] = '0;
      end
    end
  end

  assign out_valid_d = cmd_i.publish | (out_valid_q & out_stall_i);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      present_q   <= '0;
      queued_q    <= '0;
      working_q   <= '0;
      done_q      <= '0;
      pend_q      <= '0;
      free_q      <= '0;
      tick_q      <= '0;
      out_valid_q <= 1'b0;
      for (int s = 0; s < MaxSteps; s++) begin
        pred_q[s] <= '0;
      end
    end else begin
      present_q   <= present_d;
      queued_q    <= queued_d;
      working_q   <= working_d;
      done_q      <= done_d;
      pend_q      <= pend_d;
      free_q      <= free_d;
      tick_q      <= tick_d;
      out_valid_q <= out_valid_d;
      pred_q      <= pred_d;
    end
  end

  // countdowns are loaded at run start, so no reset
  always_ff @(posedge clk_i) begin
    for (int s = 0; s < MaxSteps; s++) begin
      if (cmd_i.init) begin
        wl_q[s] <= wl_init[s];
      end else if (cmd_i.decr && working_q[s]) begin
        wl_q[s] <= wl_dec[s];
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.publish) begin
      out_q.total_ticks <= tick_q;
      out_q.deadlock    <= cmd_i.dead;
    end
  end

  assign stat_o.can_start = (free_q != '0) && (queued_q != '0);
  assign stat_o.stuck     = (working_q == '0) && (unfinished != '0);
  assign stat_o.pend_any  = (pend_q != '0);
  assign stat_o.all_done  = (unfinished == '0);
  assign stat_o.out_busy  = out_valid_q & out_stall_i;

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

### hdl/dls_checker.sv
// dls_checker: port-level checks on the dependency scheduler top level
// depends on dls_pkg; bound to dependency_list_scheduler_top below
module dls_checker (
  input logic             clk_i,
  input logic             rst_ni,
  input logic             in_valid_i,
  input logic             in_stall_o,
  input dls_pkg::edge_t   in_data_i,
  input logic             out_valid_o,
  input logic             out_stall_i,
  input dls_pkg::result_t out_data_o,
  input logic             cfg_valid_i,
  input logic             cfg_ready_o
);

  // a last edge beat starts a run, so the input stalls right after it
  a_run_stalls_input: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o && in_data_i.last_edge |=> in_stall_o)
    else $error("input not stalled after last edge");

  // a result appears only out of a run
  a_result_from_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(in_stall_o))
    else $error("result without a run");

  // a stalled result beat holds
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && out_stall_i |=> out_valid_o && $stable(out_data_o))
    else $error("stalled result beat changed");

  // configuration writes are never refused
  a_cfg_taken: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cfg_valid_i |-> cfg_ready_o)
    else $error("configuration write refused");

endmodule

bind dependency_list_scheduler_top dls_checker u_dls_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_valid_i  (in_valid_i),
  .in_stall_o  (in_stall_o),
  .in_data_i   (in_data_i),
  .out_valid_o (out_valid_o),
  .out_stall_i (out_stall_i),
  .out_data_o  (out_data_o),
  .cfg_valid_i (cfg_valid_i),
  .cfg_ready_o (cfg_ready_o)
);
